FILE: rtl/ucri_pkg.sv
// Shared constants and face tables for the unit cube ray intersect core.
// No dependencies.
package ucri_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIST_W    = WORD_BITS - 1;
  localparam int PT_W      = FRAC_BITS + 2;
  localparam int K_W       = FRAC_BITS + 1;
  localparam int NUM_FACES = 6;
  localparam int SAT_SH    = DIST_W - FRAC_BITS;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [2:0] FACE_PZ = 3'd0;
  localparam logic [2:0] FACE_NZ = 3'd1;
  localparam logic [2:0] FACE_NX = 3'd2;
  localparam logic [2:0] FACE_PX = 3'd3;
  localparam logic [2:0] FACE_NY = 3'd4;
  localparam logic [2:0] FACE_PY = 3'd5;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // configuration register index
  localparam logic REG_EPS = 1'b0;

  function automatic logic [1:0] face_axis(input logic [2:0] f);
    logic [1:0] r;
    unique case (f)
      FACE_PZ, FACE_NZ: r = AX_Z;
      FACE_NX, FACE_PX: r = AX_X;
      default:          r = AX_Y;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] face_uax(input logic [2:0] f);
    logic [1:0] r;
    unique case (f)
      FACE_NX, FACE_PX: r = AX_Z;
      default:          r = AX_X;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] face_vax(input logic [2:0] f);
    logic [1:0] r;
    unique case (f)
      FACE_NY, FACE_PY: r = AX_Z;
      default:          r = AX_Y;
    endcase
    return r;
  endfunction

  function automatic logic face_pos(input logic [2:0] f);
    logic r;
    unique case (f)
      FACE_PZ, FACE_PX, FACE_PY: r = 1'b1;
      default:                   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ucri_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a side payload.
// Standalone; used by unit_cube_ray_intersect_core.
module ucri_isqrt #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int P = ROOT_W - 1 - s;
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in, rem_d;
    logic [ROOT_W-1:0] root_in, root_d;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  cur, trial;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      cur   = {rem_in, rad_in[2*P+1 -: 2]};
      trial = (REM_W + 2)'({root_in, 2'b01});
      if (cur >= trial) begin
        rem_d  = REM_W'(cur - trial);
        root_d = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(cur);
        root_d = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_in;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

FILE: rtl/ucri_div.sv
// Pipelined restoring divider, several lanes, one quotient bit per stage.
// Standalone; the caller guarantees num < den * 2^QUO_W or masks the result.
module ucri_div #(
  parameter int LANES  = 3,
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][NUM_W-1:0]      num_i,
  input  logic [LANES-1:0][DEN_W-1:0]      den_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic [LANES-1:0][QUO_W-1:0]      quo_o,
  output logic [SIDE_W-1:0]                side_o
);

  logic                           vld_q  [QUO_W];
  logic [LANES-1:0][NUM_W-1:0]    num_q  [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]    den_q  [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]    rem_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]    quo_q  [QUO_W];
  logic [SIDE_W-1:0]              side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic                        vld_in;
    logic [LANES-1:0][NUM_W-1:0] num_in;
    logic [LANES-1:0][DEN_W-1:0] den_in, rem_in, rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_in, quo_d;
    logic [SIDE_W-1:0]           side_in;
    logic [DEN_W:0]              trial [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        num_in  = num_i;
        den_in  = den_i;
        quo_in  = '0;
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = DEN_W'(num_i[l] >> QUO_W);
        end
      end
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign num_in  = num_q[s-1];
      assign den_in  = den_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      quo_d = quo_in;
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_in[l], num_in[l][B]};
        if (trial[l] >= {1'b0, den_in[l]}) begin
          rem_d[l]    = DEN_W'(trial[l] - {1'b0, den_in[l]});
          quo_d[l][B] = 1'b1;
        end else begin
          rem_d[l] = trial[l][DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= num_in;
        den_q[s]  <= den_in;
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

FILE: rtl/unit_cube_ray_intersect_core.sv
// Stages: 3 front, 32 root, 17 for the unit direction, 31 distance, 5 tail.
// Throughput: one ray per cycle unless stalled; each root or divider stage
// resolves one root or quotient bit. The output register stalls the pipe only
// when it holds a word that is not taken (m_axis_tready low) and the last
// stage is full. Reset clears all valid bits and sets parallel_epsilon to 1.
// Depends on ucri_pkg, ucri_isqrt and ucri_div.
module unit_cube_ray_intersect_core
  import ucri_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // ray in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z (32 each)
  input  logic [191:0] s_axis_tdata,
  // hit result out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // face[2:0], distance[33:3], point_x, point_y, point_z, face_u, face_v (18 each)
  output logic [127:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  localparam int W = WORD_BITS;
  localparam logic [W:0] ONE_NUM = (W + 1)'(1) << FRAC_BITS;
  localparam logic signed [W+1:0] ONE_U = (W + 2)'(1) << FRAC_BITS;
  localparam logic [PT_W-1:0] ONE_PT = PT_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0]        neg;
    logic [2:0][W-1:0] dm;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][W-1:0] a;
    logic [2:0]        neg;
    logic              len_zero;
  } k_side_t;

  typedef struct packed {
    logic [2:0][W-1:0]           a;
    logic [2:0]                  neg;
    logic [2:0][K_W-1:0]         km;
    logic [NUM_FACES-1:0]        ok;
    logic [NUM_FACES-1:0]        sat;
  } t_side_t;

  typedef struct packed {
    logic              v;
    logic [2:0]        face;
    logic [DIST_W-1:0] t;
    logic [PT_W-1:0]   u;
    logic [PT_W-1:0]   w;
  } cand_t;

  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    return (hi.v && (!lo.v || hi.t < lo.t)) ? hi : lo;
  endfunction

  // ---------------------------------------------------------------- config
  logic [15:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= 16'd1;
    end else if (psel && penable && pwrite && paddr[2] == REG_EPS) begin
      eps_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EPS) ? {16'd0, eps_q} : 32'd0;

  // ---------------------------------------------------------------- flow
  logic  en;
  logic  b_valid_q;
  logic  out_valid_q;

  assign en            = !b_valid_q || !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- stage 1
  logic              s1_valid_q;
  logic [2:0][W-1:0] s1_a_q, s1_dm_q, s1_a_d, s1_dm_d;
  logic [2:0]        s1_neg_q, s1_neg_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_a_d[i]   = s_axis_tdata[i*W +: W];
      s1_neg_d[i] = s_axis_tdata[(3+i)*W + W - 1];
      s1_dm_d[i]  = s1_neg_d[i] ? (~s_axis_tdata[(3+i)*W +: W]) + W'(1)
                                : s_axis_tdata[(3+i)*W +: W];
    end
  end

  // ---------------------------------------------------------------- stage 2, 3
  logic                s2_valid_q, s3_valid_q;
  logic [2:0][2*W-1:0] s2_sq_q;
  sq_side_t            s2_side_q, s3_side_q;
  logic [2*W-1:0]      s3_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q   <= s1_a_d;
      s1_neg_q <= s1_neg_d;
      s1_dm_q  <= s1_dm_d;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= s1_dm_q[i] * s1_dm_q[i];
      end
      s2_side_q <= '{a: s1_a_q, neg: s1_neg_q, dm: s1_dm_q};
      s3_sum_q  <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
      s3_side_q <= s2_side_q;
    end
  end

  // ---------------------------------------------------------------- length
  logic     sq_valid;
  logic [W-1:0] len;
  sq_side_t sq_side;

  ucri_isqrt #(
    .RAD_W  (2 * W),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .rad_i   (s3_sum_q),
    .side_i  (s3_side_q),
    .valid_o (sq_valid),
    .root_o  (len),
    .side_o  (sq_side)
  );

  // ---------------------------------------------------------------- unit direction
  logic [2:0][W+FRAC_BITS-1:0] k_num;
  logic [2:0][W-1:0]           k_den;
  k_side_t                     k_side_in, k_side;
  logic                        k_valid;
  logic [2:0][K_W-1:0]         km;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_num[i] = {sq_side.dm[i], FRAC_BITS'(0)};
      k_den[i] = len;
    end
    k_side_in = '{a: sq_side.a, neg: sq_side.neg, len_zero: (len == '0)};
  end

  ucri_div #(
    .LANES  (3),
    .NUM_W  (W + FRAC_BITS),
    .DEN_W  (W),
    .QUO_W  (K_W),
    .SIDE_W ($bits(k_side_t))
  ) u_kdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (k_num),
    .den_i   (k_den),
    .side_i  (k_side_in),
    .valid_o (k_valid),
    .quo_o   (km),
    .side_o  (k_side)
  );

  // ---------------------------------------------------------------- face setup
  logic                                  p_valid_q;
  logic [NUM_FACES-1:0][W:0]             p_nmag_q, p_nmag_d;
  logic [NUM_FACES-1:0][K_W-1:0]         p_den_q, p_den_d;
  t_side_t                               p_side_q, p_side_d;

  always_comb begin
    logic [1:0]     ax;
    logic [W:0]     numv;
    logic           nonpar;
    p_side_d.a   = k_side.a;
    p_side_d.neg = k_side.neg;
    p_side_d.km  = km;
    for (int f = 0; f < NUM_FACES; f++) begin
      ax          = face_axis(3'(f));
      nonpar      = (km[ax] != '0) && (km[ax] >= K_W'(eps_q));
      numv        = (face_pos(3'(f)) ? ONE_NUM : -ONE_NUM) - {k_side.a[ax][W-1], k_side.a[ax]};
      p_nmag_d[f] = numv[W] ? -numv : numv;
      p_den_d[f]  = km[ax];
      p_side_d.ok[f]  = !k_side.len_zero && nonpar && (numv != '0) &&
                        (numv[W] == k_side.neg[ax]);
      // quotient would not fit below 2^DIST_W
      p_side_d.sat[f] = p_nmag_d[f] >= (W + 1)'({km[ax], SAT_SH'(0)});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= k_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_nmag_q <= p_nmag_d;
      p_den_q  <= p_den_d;
      p_side_q <= p_side_d;
    end
  end

  // ---------------------------------------------------------------- distance
  logic [NUM_FACES-1:0][W+1+FRAC_BITS-1:0] t_num;
  logic                                    t_valid;
  logic [NUM_FACES-1:0][DIST_W-1:0]        t_quo;
  t_side_t                                 t_side;

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      t_num[f] = {p_nmag_q[f], FRAC_BITS'(0)};
    end
  end

  ucri_div #(
    .LANES  (NUM_FACES),
    .NUM_W  (W + 1 + FRAC_BITS),
    .DEN_W  (K_W),
    .QUO_W  (DIST_W),
    .SIDE_W ($bits(t_side_t))
  ) u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid_q),
    .num_i   (t_num),
    .den_i   (p_den_q),
    .side_i  (p_side_q),
    .valid_o (t_valid),
    .quo_o   (t_quo),
    .side_o  (t_side)
  );

  // ---------------------------------------------------------------- face coordinates
  logic                                  m_valid_q, a_valid_q;
  logic [NUM_FACES-1:0][K_W+DIST_W-1:0]  m_pu_q, m_pv_q;
  logic [NUM_FACES-1:0][DIST_W-1:0]      m_t_q, a_t_q;
  logic [NUM_FACES-1:0]                  m_tv_q, a_ok_q, a_ok_d;
  logic [2:0][W-1:0]                     m_a_q;
  logic [2:0]                            m_neg_q;
  logic [NUM_FACES-1:0][PT_W-1:0]        a_u_q, a_v_q, a_u_d, a_v_d;

  always_comb begin
    logic [1:0]          ua, va;
    logic signed [W+1:0] su, sv;
    for (int f = 0; f < NUM_FACES; f++) begin
      ua = face_uax(3'(f));
      va = face_vax(3'(f));
      su = $signed({{2{m_a_q[ua][W-1]}}, m_a_q[ua]});
      sv = $signed({{2{m_a_q[va][W-1]}}, m_a_q[va]});
      if (m_neg_q[ua]) su = su - $signed({2'b00, m_pu_q[f][FRAC_BITS +: W]});
      else             su = su + $signed({2'b00, m_pu_q[f][FRAC_BITS +: W]});
      if (m_neg_q[va]) sv = sv - $signed({2'b00, m_pv_q[f][FRAC_BITS +: W]});
      else             sv = sv + $signed({2'b00, m_pv_q[f][FRAC_BITS +: W]});
      a_ok_d[f] = m_tv_q[f] && (su <= ONE_U) && (su >= -ONE_U) &&
                  (sv <= ONE_U) && (sv >= -ONE_U);
      a_u_d[f]  = su[PT_W-1:0];
      a_v_d[f]  = sv[PT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= t_valid;
      a_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        m_pu_q[f] <= t_side.km[face_uax(3'(f))] * t_quo[f];
        m_pv_q[f] <= t_side.km[face_vax(3'(f))] * t_quo[f];
        m_tv_q[f] <= t_side.ok[f] && !t_side.sat[f] && (t_quo[f] != '0) &&
                     (t_quo[f] != DIST_MAX);
      end
      m_t_q   <= t_quo;
      m_a_q   <= t_side.a;
      m_neg_q <= t_side.neg;
      a_t_q   <= m_t_q;
      a_ok_q  <= a_ok_d;
      a_u_q   <= a_u_d;
      a_v_q   <= a_v_d;
    end
  end

  // ---------------------------------------------------------------- nearest face
  cand_t b_c_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        b_c_q[p] <= pick('{v: a_ok_q[2*p], face: 3'(2*p), t: a_t_q[2*p],
                           u: a_u_q[2*p], w: a_v_q[2*p]},
                         '{v: a_ok_q[2*p+1], face: 3'(2*p+1), t: a_t_q[2*p+1],
                           u: a_u_q[2*p+1], w: a_v_q[2*p+1]});
      end
    end
  end

  // ---------------------------------------------------------------- output word
  cand_t                 best;
  logic                  out_load;
  logic                  o_hit_q;
  logic [2:0]            o_face_q;
  logic [DIST_W-1:0]     o_dist_q;
  logic [2:0][PT_W-1:0]  o_pt_q, o_pt_d;
  logic [PT_W-1:0]       o_u_q, o_v_q;

  assign best     = pick(pick(b_c_q[0], b_c_q[1]), b_c_q[2]);
  assign out_load = en && b_valid_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!best.v)                               o_pt_d[j] = '0;
      else if (face_axis(best.face) == 2'(j))    o_pt_d[j] = face_pos(best.face) ? ONE_PT
                                                                                 : -ONE_PT;
      else if (face_uax(best.face) == 2'(j))     o_pt_d[j] = best.u;
      else                                       o_pt_d[j] = best.w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_hit_q  <= best.v;
      o_face_q <= best.v ? best.face : FACE_PZ;
      o_dist_q <= best.v ? best.t : DIST_MAX;
      o_pt_q   <= o_pt_d;
      o_u_q    <= best.v ? best.u : '0;
      o_v_q    <= best.v ? best.w : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_hit_q;
  assign m_axis_tdata  = {4'd0, o_v_q, o_u_q, o_pt_q[2], o_pt_q[1], o_pt_q[0],
                          o_dist_q, o_face_q};

  // ---------------------------------------------------------------- checks
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> out_valid_q && b_valid_q)
    else $error("pipe stalled without a waiting word");

  a_hit_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_hit_q |-> o_dist_q != DIST_MAX && o_dist_q != '0)
    else $error("hit with zero or saturated distance");

  a_miss_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !o_hit_q |-> o_face_q == FACE_PZ && o_dist_q == DIST_MAX)
    else $error("miss word not cleared");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_hit_q |-> o_face_q <= FACE_PY)
    else $error("face index out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_valid_q |-> m_axis_tready)
    else $error("output word overwritten");

endmodule
